/* src/oas_pkg.sv */
package oas_pkg;

  localparam int THR_W   = 12;
  localparam int FWD_W   = 10;
  localparam int TURN_W  = 10;
  localparam int GAIN_W  = 10;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 3;
  localparam int SPEED_W = 12;
  localparam int SIDE_W  = 2;
  localparam int Q_FRAC  = 8;

  localparam logic [THR_W-1:0]  THR_RST       = THR_W'(100);
  localparam logic [FWD_W-1:0]  FWD_RST       = FWD_W'(150);
  localparam logic [TURN_W-1:0] TURN_RST      = TURN_W'(600);
  localparam logic [GAIN_W-1:0] GAIN_SIDE_RST = GAIN_W'(51);
  localparam logic [GAIN_W-1:0] GAIN_DIAG_RST = GAIN_W'(230);
  localparam logic [GAIN_W-1:0] GAIN_FRNT_RST = GAIN_W'(307);

  typedef enum logic [SIDE_W-1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_FORWARD   = 3'd1,
    CFG_MAX_TURN  = 3'd2,
    CFG_GAIN_SIDE = 3'd3,
    CFG_GAIN_DIAG = 3'd4,
    CFG_GAIN_FRNT = 3'd5
  } cfg_idx_t;

endpackage

/* src/obstacle_avoidance_steering_unit.sv */
// path: a request is held in the input register, then handed on to the result register
// throughput: one request per cycle while out_ready holds; active flag and latched side update as the
//   input register hands its request to the result register, so the next one sees them
// reset (rst, synchronous): both stages empty, avoidance inactive, no side latched,
//   registers back to threshold 100, forward 150, max turn 600, gains 51/230/307
module obstacle_avoidance_steering_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [oas_pkg::IDX_W-1:0]    cfg_index,
  input  logic [oas_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         clear_request,
  input  logic [SAMPLE_BITS-1:0]       prox_right_front,
  input  logic [SAMPLE_BITS-1:0]       prox_right_diag,
  input  logic [SAMPLE_BITS-1:0]       prox_right_side,
  input  logic [SAMPLE_BITS-1:0]       prox_left_side,
  input  logic [SAMPLE_BITS-1:0]       prox_left_diag,
  input  logic [SAMPLE_BITS-1:0]       prox_left_front,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [oas_pkg::SPEED_W-1:0]  left_speed,
  output logic [oas_pkg::SPEED_W-1:0]  right_speed,
  output logic                         avoiding,
  output logic [oas_pkg::SIDE_W-1:0]   obstacle_side
);
  import oas_pkg::*;

  localparam int CMP_W  = SAMPLE_BITS + THR_W;
  localparam int PAIR_W = SAMPLE_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int TERM_W = PROD_W - Q_FRAC;
  localparam int SUM_W  = TERM_W + 2;
  localparam int CALC_W = SPEED_W + 1;

  // configuration registers
  logic [THR_W-1:0]  obstacle_threshold;
  logic [FWD_W-1:0]  forward_speed;
  logic [TURN_W-1:0] max_turn;
  logic [GAIN_W-1:0] gain_side;
  logic [GAIN_W-1:0] gain_diagonal;
  logic [GAIN_W-1:0] gain_front;

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_threshold <= THR_RST;
      forward_speed      <= FWD_RST;
      max_turn           <= TURN_RST;
      gain_side          <= GAIN_SIDE_RST;
      gain_diagonal      <= GAIN_DIAG_RST;
      gain_front         <= GAIN_FRNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: obstacle_threshold <= cfg_data[THR_W-1:0];
        CFG_FORWARD:   forward_speed      <= cfg_data[FWD_W-1:0];
        CFG_MAX_TURN:  max_turn           <= cfg_data[TURN_W-1:0];
        CFG_GAIN_SIDE: gain_side          <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_DIAG: gain_diagonal      <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_FRNT: gain_front         <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                   s1_valid;
  logic                   s1_clear;
  logic [SAMPLE_BITS-1:0] s1_rf, s1_rd, s1_rs, s1_ls, s1_ld, s1_lf;
  logic                   s1_advance;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_clear <= clear_request;
      s1_rf    <= prox_right_front;
      s1_rd    <= prox_right_diag;
      s1_rs    <= prox_right_side;
      s1_ls    <= prox_left_side;
      s1_ld    <= prox_left_diag;
      s1_lf    <= prox_left_front;
    end
  end

  // steering state
  logic  active;
  side_t side;
  logic  active_next;
  side_t side_next;

  logic                   act_base;
  side_t                  side_base;
  logic [CMP_W-1:0]       thr_ext;
  logic                   peak_hit;
  logic [PAIR_W-1:0]      right_pair, left_pair;
  logic                   turn_right;
  logic [SAMPLE_BITS-1:0] sel_s, sel_d, sel_f;
  logic [PROD_W-1:0]      prod_s, prod_d, prod_f;
  logic [SUM_W-1:0]       turn_sum;
  logic [TURN_W-1:0]      mag;
  logic [CALC_W-1:0]      fwd_ext, mag_ext, speed_plus, speed_minus;
  logic [SPEED_W-1:0]     left_next, right_next;

  always_comb begin
    act_base  = s1_clear ? 1'b0 : active;
    side_base = s1_clear ? SIDE_NONE : side;

    thr_ext  = CMP_W'(obstacle_threshold);
    peak_hit = (CMP_W'(s1_rf) > thr_ext) || (CMP_W'(s1_rd) > thr_ext)
            || (CMP_W'(s1_ld) > thr_ext) || (CMP_W'(s1_lf) > thr_ext);
    active_next = act_base || peak_hit;

    right_pair = PAIR_W'(s1_rf) + PAIR_W'(s1_rd);
    left_pair  = PAIR_W'(s1_lf) + PAIR_W'(s1_ld);
    side_next  = side_base;
    if (active_next && side_base == SIDE_NONE) begin
      // a tie goes left
      side_next = (right_pair > left_pair) ? SIDE_RIGHT : SIDE_LEFT;
    end

    turn_right = (side_next == SIDE_RIGHT);
    sel_s = turn_right ? s1_rs : s1_ls;
    sel_d = turn_right ? s1_rd : s1_ld;
    sel_f = turn_right ? s1_rf : s1_lf;

    prod_s = PROD_W'(gain_side) * PROD_W'(sel_s);
    prod_d = PROD_W'(gain_diagonal) * PROD_W'(sel_d);
    prod_f = PROD_W'(gain_front) * PROD_W'(sel_f);
    turn_sum = SUM_W'(prod_s[PROD_W-1:Q_FRAC]) + SUM_W'(prod_d[PROD_W-1:Q_FRAC])
             + SUM_W'(prod_f[PROD_W-1:Q_FRAC]);

    if (!active_next) begin
      mag = '0;
    end else if (turn_sum > SUM_W'(max_turn)) begin
      mag = max_turn;
    end else begin
      mag = turn_sum[TURN_W-1:0];
    end

    fwd_ext     = CALC_W'(forward_speed);
    mag_ext     = CALC_W'(mag);
    speed_plus  = fwd_ext + mag_ext;
    speed_minus = fwd_ext - mag_ext;
    // an obstacle on the right slows the left wheel
    left_next  = turn_right ? speed_minus[SPEED_W-1:0] : speed_plus[SPEED_W-1:0];
    right_next = turn_right ? speed_plus[SPEED_W-1:0] : speed_minus[SPEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      side   <= SIDE_NONE;
    end else if (s1_advance) begin
      active <= active_next;
      side   <= side_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      left_speed    <= left_next;
      right_speed   <= right_next;
      avoiding      <= active_next;
      obstacle_side <= side_next;
    end
  end

endmodule

/* src/oas_checker.sv */
module oas_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [oas_pkg::SPEED_W-1:0]  left_speed,
  input logic [oas_pkg::SPEED_W-1:0]  right_speed,
  input logic                         avoiding,
  input logic [oas_pkg::SIDE_W-1:0]   obstacle_side
);
  import oas_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_speed) && $stable(right_speed)
      && $stable(avoiding) && $stable(obstacle_side))
    else $error("stalled result changed");

  // inactive means no side and equal wheel speeds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !avoiding |-> obstacle_side == SIDE_NONE && left_speed == right_speed)
    else $error("inactive result shows a side or a turn");

  // active always carries a latched side
  assert property (@(posedge clk) disable iff (rst)
    out_valid && avoiding |-> obstacle_side == SIDE_LEFT || obstacle_side == SIDE_RIGHT)
    else $error("active result without a side");

  // steering turns away from the latched side
  assert property (@(posedge clk) disable iff (rst)
    out_valid && obstacle_side == SIDE_LEFT |-> $signed(left_speed) >= $signed(right_speed))
    else $error("left obstacle did not steer right");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && obstacle_side == SIDE_RIGHT |-> $signed(right_speed) >= $signed(left_speed))
    else $error("right obstacle did not steer left");

endmodule

bind obstacle_avoidance_steering_unit oas_checker u_oas_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .left_speed    (left_speed),
  .right_speed   (right_speed),
  .avoiding      (avoiding),
  .obstacle_side (obstacle_side)
);
